// File: src/rml_pkg.sv
package rml_pkg;

  localparam int ROW_WIDTH_W = 11;
  localparam logic [ROW_WIDTH_W-1:0] ROW_WIDTH_RESET = 11'd1024;
  localparam int MAX_WIDTH_DEFAULT = 1024;
  localparam int QUEUE_DEPTH = 4;
  localparam int PIXEL_W = 24;

  typedef struct packed {
    logic [7:0] red_in;
    logic [7:0] green_in;
    logic [7:0] blue_in;
    logic       image_start;
  } pixel_in_t;

  typedef struct packed {
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;
    logic       out_valid;
    logic       row_end;
  } pixel_out_t;

  typedef struct packed {
    logic issue;
    logic have_prev;
    logic last;
  } front_cmd_t;

endpackage

// File: src/rml_ram.sv
module rml_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: src/rml_front.sv
module rml_front #(
  parameter int MAX_WIDTH = rml_pkg::MAX_WIDTH_DEFAULT
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [rml_pkg::ROW_WIDTH_W-1:0]     cfg_wdata,
  input  logic                                accept,
  input  rml_pkg::pixel_in_t                  pixel,
  output logic                                ram_we,
  output logic [$clog2(2*MAX_WIDTH)-1:0]      ram_waddr,
  output logic [rml_pkg::PIXEL_W-1:0]         ram_wdata,
  output logic [$clog2(2*MAX_WIDTH)-1:0]      ram_raddr,
  output rml_pkg::front_cmd_t                 cmd
);
  import rml_pkg::*;

  localparam int AW = $clog2(MAX_WIDTH);
  localparam int RAW = $clog2(2*MAX_WIDTH);
  localparam int MW = $clog2(MAX_WIDTH + 1);
  localparam int EW = (ROW_WIDTH_W > MW) ? ROW_WIDTH_W : MW;

  logic [ROW_WIDTH_W-1:0] row_width;
  logic [AW-1:0]          column_count;
  logic                   bank_select;
  logic                   have_previous_row;

  logic [EW-1:0] width_ext;
  logic [EW-1:0] width_eff;
  logic [AW-1:0] width_last;
  logic [AW-1:0] col_base;
  logic          bank;
  logic          have_prev;
  logic [AW-1:0] col;
  logic [AW-1:0] mirror;
  logic          last;

  always_comb begin
    width_ext = EW'(row_width);
    if (width_ext == '0) begin
      width_eff = EW'(1);
    end else if (width_ext > EW'(MAX_WIDTH)) begin
      width_eff = EW'(MAX_WIDTH);
    end else begin
      width_eff = width_ext;
    end
    width_last = AW'(width_eff - EW'(1));

    col_base  = pixel.image_start ? '0 : column_count;
    bank      = pixel.image_start ? 1'b0 : bank_select;
    have_prev = pixel.image_start ? 1'b0 : have_previous_row;

    col    = (EW'(col_base) >= width_eff) ? width_last : col_base;
    mirror = width_last - col;
    last   = (col == width_last);

    ram_we    = accept;
    ram_waddr = bank ? RAW'(MAX_WIDTH) + RAW'(col) : RAW'(col);
    ram_raddr = bank ? RAW'(mirror) : RAW'(MAX_WIDTH) + RAW'(mirror);
    ram_wdata = {pixel.red_in, pixel.green_in, pixel.blue_in};

    cmd.issue     = accept;
    cmd.have_prev = have_prev;
    cmd.last      = last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_width         <= ROW_WIDTH_RESET;
      column_count      <= '0;
      bank_select       <= 1'b0;
      have_previous_row <= 1'b0;
    end else begin
      if (cfg_we) begin
        row_width <= cfg_wdata;
      end
      if (accept) begin
        if (last) begin
          column_count      <= '0;
          bank_select       <= ~bank;
          have_previous_row <= 1'b1;
        end else begin
          column_count      <= col + AW'(1);
          bank_select       <= bank;
          have_previous_row <= have_prev;
        end
      end
    end
  end

endmodule

// File: src/rml_back.sv
module rml_back (
  input  logic                        clk,
  input  logic                        rst,
  input  rml_pkg::front_cmd_t         cmd,
  input  logic [rml_pkg::PIXEL_W-1:0] ram_rdata,
  output logic                        full,
  output logic                        result_valid,
  input  logic                        result_stall,
  output rml_pkg::pixel_out_t         result
);
  import rml_pkg::*;

  localparam int PW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  logic          s1_valid;
  logic          s1_have;
  logic          s1_last;
  pixel_out_t    queue [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] fill;
  logic [CW-1:0] slots;
  logic          pop;
  pixel_out_t    entry;

  assign pop          = result_valid && !result_stall;
  assign result_valid = (fill != '0);
  assign result       = queue[rd_ptr];
  assign full         = (slots == CW'(QUEUE_DEPTH));

  always_comb begin
    if (s1_have) begin
      entry.red_out   = ram_rdata[23:16];
      entry.green_out = ram_rdata[15:8];
      entry.blue_out  = ram_rdata[7:0];
      entry.out_valid = 1'b1;
      entry.row_end   = s1_last;
    end else begin
      entry = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      wr_ptr   <= '0;
      rd_ptr   <= '0;
      fill     <= '0;
      slots    <= '0;
    end else begin
      s1_valid <= cmd.issue;
      if (s1_valid) begin
        wr_ptr <= (wr_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      fill  <= fill + CW'(s1_valid) - CW'(pop);
      slots <= slots + CW'(cmd.issue) - CW'(pop);
    end
  end

  always_ff @(posedge clk) begin
    s1_have <= cmd.have_prev;
    s1_last <= cmd.last;
    if (s1_valid) begin
      queue[wr_ptr] <= entry;
    end
  end

endmodule

// File: src/row_mirror_line_buffer.sv
// Mirrors each image row left to right and accepts one pixel beat per clock for as long as
// the result side keeps up. Each accepted pixel is written into one half of a row-buffer RAM
// of 2*MAX_WIDTH entries while the mirrored pixel of the previous row is read from the other
// half, so the RAM's one write and one read port per cycle set the rate. A result beat passes
// through the registered RAM read and the result queue, and the output shows the previous row,
// so the image appears one row late; during the first row of an image the result beats carry
// out_valid low and zero color. A queue of four results parts the two sides. The RAM is not
// cleared after reset; the user must write row_width only while idle (block does not check).
module row_mirror_line_buffer #(
  parameter int MAX_WIDTH = rml_pkg::MAX_WIDTH_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [rml_pkg::ROW_WIDTH_W-1:0] cfg_wdata,
  input  logic                            pixel_valid,
  output logic                            pixel_stall,
  input  rml_pkg::pixel_in_t              pixel,
  output logic                            result_valid,
  input  logic                            result_stall,
  output rml_pkg::pixel_out_t             result
);
  import rml_pkg::*;

  localparam int RAW = $clog2(2*MAX_WIDTH);

  logic               accept;
  logic               full;
  logic               ram_we;
  logic [RAW-1:0]     ram_waddr;
  logic [RAW-1:0]     ram_raddr;
  logic [PIXEL_W-1:0] ram_wdata;
  logic [PIXEL_W-1:0] ram_rdata;
  front_cmd_t         cmd;

  assign pixel_stall = full;
  assign accept      = pixel_valid && !full;

  rml_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .accept    (accept),
    .pixel     (pixel),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_raddr (ram_raddr),
    .cmd       (cmd)
  );

  rml_ram #(.WIDTH(PIXEL_W), .DEPTH(2*MAX_WIDTH)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  rml_back u_back (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .ram_rdata    (ram_rdata),
    .full         (full),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

endmodule

// File: src/rml_checker.sv
module rml_checker (
  input logic                clk,
  input logic                rst,
  input logic                pixel_stall,
  input logic                result_valid,
  input logic                result_stall,
  input rml_pkg::pixel_out_t result
);

  a_reset_ready: assert property (@(posedge clk) rst |=> !pixel_stall)
    else $error("Pixel beats refused right after reset.");

  a_reset_empty: assert property (@(posedge clk) rst |=> !result_valid)
    else $error("Result beat offered right after reset.");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(result))
    else $error("Stalled result beat changed.");

  a_row_end_valid: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.row_end |-> result.out_valid)
    else $error("Row end flagged on a first-row beat.");

  a_first_row_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.out_valid |->
      result.red_out == 8'd0 && result.green_out == 8'd0 && result.blue_out == 8'd0)
    else $error("First-row beat carries color.");

endmodule

bind row_mirror_line_buffer rml_checker u_rml_checker (
  .clk          (clk),
  .rst          (rst),
  .pixel_stall  (pixel_stall),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .result       (result)
);

// File: tb/mirror_checker.sv
module mirror_checker
  import rml_pkg::*;
#(
  parameter int MAX_WIDTH = MAX_WIDTH_DEFAULT
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [ROW_WIDTH_W-1:0] cfg_wdata,
  input  logic                   pixel_valid,
  input  logic                   pixel_stall,
  input  pixel_in_t              pixel,
  input  logic                   result_valid,
  input  logic                   result_stall,
  input  pixel_out_t             result,
  output int                     error_count,
  output int                     pending
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [PIXEL_W-1:0]     line_mem [2*MAX_WIDTH];
  logic [ROW_WIDTH_W-1:0] width_reg;
  int unsigned            column;
  int unsigned            bank;
  logic                   have_prev;
  pixel_out_t             expected_pixels [$];

  task automatic mirror_pixel(input pixel_in_t p);
    int unsigned        w;
    int unsigned        col;
    int unsigned        mir;
    logic               last;
    logic [PIXEL_W-1:0] prev;
    pixel_out_t         e;
    w = width_reg;
    if (w == 0) w = 1;
    if (w > MAX_WIDTH) w = MAX_WIDTH;
    if (p.image_start) begin
      column = 0;
      bank = 0;
      have_prev = 1'b0;
    end
    col = (column >= w) ? w - 1 : column;
    mir = w - 1 - col;
    last = (col == w - 1);
    prev = line_mem[(bank ^ 1) * MAX_WIDTH + mir];
    line_mem[bank * MAX_WIDTH + col] = {p.red_in, p.green_in, p.blue_in};
    e = '0;
    if (have_prev) begin
      e.red_out = prev[23:16];
      e.green_out = prev[15:8];
      e.blue_out = prev[7:0];
      e.out_valid = 1'b1;
      e.row_end = last;
    end
    expected_pixels.push_back(e);
    if (last) begin
      column = 0;
      bank ^= 1;
      have_prev = 1'b1;
    end else begin
      column = col + 1;
    end
  endtask

  task automatic compare_pixel(input pixel_out_t got);
    pixel_out_t e;
    if (expected_pixels.size() == 0) begin
      error_count++;
      if (error_count <= 10)
        $display("%0t: result beat with nothing expected: %p", $realtime, got);
    end else begin
      e = expected_pixels.pop_front();
      if (got.red_out !== e.red_out || got.green_out !== e.green_out ||
          got.blue_out !== e.blue_out || got.out_valid !== e.out_valid ||
          got.row_end !== e.row_end) begin
        error_count++;
        if (error_count <= 10)
          $display("%0t: mismatch, expected %p, got %p", $realtime, e, got);
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      width_reg = ROW_WIDTH_RESET;
      column = 0;
      bank = 0;
      have_prev = 1'b0;
      expected_pixels.delete();
    end else begin
      if (result_valid && !result_stall) compare_pixel(result);
      if (pixel_valid && !pixel_stall) mirror_pixel(pixel);
      if (cfg_we) width_reg = cfg_wdata;
    end
    pending = expected_pixels.size();
  end

endmodule

// File: tb/tb_top.sv
module tb_top;
  import rml_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic                   clk;
  logic                   rst;
  logic                   cfg_we;
  logic [ROW_WIDTH_W-1:0] cfg_wdata;
  logic                   pixel_valid;
  logic                   pixel_stall;
  pixel_in_t              pixel;
  logic                   result_valid;
  logic                   result_stall;
  pixel_out_t             result;
  int                     error_count;
  int                     pending;
  logic                   calm;

  row_mirror_line_buffer i_dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .pixel_valid (pixel_valid),
    .pixel_stall (pixel_stall),
    .pixel       (pixel),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result      (result)
  );

  mirror_checker i_checker (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .pixel_valid (pixel_valid),
    .pixel_stall (pixel_stall),
    .pixel       (pixel),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result      (result),
    .error_count (error_count),
    .pending     (pending)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #1ms;
    $display("FAIL");
    $finish;
  end

  always @(negedge clk) begin
    result_stall <= !rst && !calm && ($urandom_range(99) < 18);
  end

  function automatic logic [7:0] pick_color();
    if ($urandom_range(9) == 0) return $urandom_range(1) ? 8'hff : 8'h00;
    return 8'($urandom_range(255));
  endfunction

  task automatic send_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b,
                            input logic start);
    while (!calm && $urandom_range(99) < 18) begin
      pixel_valid <= 1'b0;
      @(negedge clk);
    end
    pixel_valid <= 1'b1;
    pixel <= '{red_in: r, green_in: g, blue_in: b, image_start: start};
    @(posedge clk);
    while (pixel_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_image(input int unsigned count, input bit noisy);
    bit start;
    for (int unsigned i = 0; i < count; i++) begin
      start = (i == 0) || (noisy && $urandom_range(99) < 3);
      send_pixel(pick_color(), pick_color(), pick_color(), start);
    end
  endtask

  // The row width may only change once the block has drained.
  task automatic set_width(input int unsigned w);
    pixel_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= ROW_WIDTH_W'(w);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    int unsigned sent;
    int unsigned w;
    int unsigned eff;
    int unsigned count;
    int unsigned pick;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    pixel_valid = 1'b0;
    pixel = '0;
    result_stall = 1'b0;
    calm = 1'b0;
    repeat (12) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    set_width(4);
    send_pixel(8'hff, 8'hff, 8'hff, 1'b1);
    send_pixel(8'h00, 8'h00, 8'h00, 1'b0);
    send_pixel(8'hff, 8'h00, 8'hff, 1'b0);
    send_pixel(8'h00, 8'hff, 8'h00, 1'b0);
    send_image(0, 1'b0);
    for (int i = 0; i < 7; i++) send_pixel(pick_color(), pick_color(), pick_color(), 1'b0);
    // Narrow the row while three of its pixels are in; the next beat closes the row.
    set_width(2);
    for (int i = 0; i < 4; i++) send_pixel(pick_color(), pick_color(), pick_color(), 1'b0);
    send_image(3, 1'b0);
    set_width(0);
    send_image(3, 1'b0);
    set_width(1);
    send_image(2, 1'b0);

    // A wide image without any idling, then an oversized width that saturates.
    calm = 1'b1;
    set_width(200);
    send_image(2 * 200 + 32, 1'b0);
    set_width(2047);
    send_image(48, 1'b0);
    calm = 1'b0;

    sent = 0;
    while (sent < 440) begin
      pick = $urandom_range(99);
      if (pick < 5) w = 0;
      else if (pick < 12) w = $urandom_range(17, 64);
      else w = $urandom_range(1, 16);
      set_width(w);
      eff = (w == 0) ? 1 : w;
      count = eff * $urandom_range(1, 5) + $urandom_range(0, eff - 1);
      send_image(count, 1'b1);
      sent += count;
    end

    pixel_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (10) @(negedge clk);
    if (error_count == 0 && pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// File: files.f
src/rml_pkg.sv
src/rml_ram.sv
src/rml_front.sv
src/rml_back.sv
src/row_mirror_line_buffer.sv
src/rml_checker.sv
tb/mirror_checker.sv
tb/tb_top.sv
